// ===== rtl/fsv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsv_pkg
// Shared types and constants of the module file signature validator.
// ----------------------------------------------------------------------------
package fsv_pkg;

	// Sizes of the stored file and the list walks
	localparam int MAX_LEN_DEF      = 131072;
	localparam int LIST_ENTRIES_DEF = 256;
	localparam int SCAN_LIMIT_DEF   = 1024;

	// Widths fixed by the item fields and the 16-bit pointers
	localparam int BYTE_W  = 8;
	localparam int WORD_W  = 16;
	localparam int OFF_W   = 17;
	localparam int LEN_W   = 17;

	// Header layout
	localparam int MAGIC_LEN = 8;
	localparam logic [BYTE_W-1:0] MAGIC [MAGIC_LEN] = '{
		8'h54, 8'h42, 8'h53, 8'h41, 8'h30, 8'h2E, 8'h30, 8'h31
	};
	localparam logic [OFF_W-1:0] HDR_ORDER_OFF = 17'd8;
	localparam logic [OFF_W-1:0] HDR_INST_OFF  = 17'd16;
	localparam logic [OFF_W-1:0] HDR_SEG_OFF   = 17'd18;

	localparam logic [WORD_W-1:0] END_MARK  = 16'hFFFF;
	localparam logic [BYTE_W-1:0] SEG_END   = 8'hFF;
	localparam logic [OFF_W-1:0]  INST_SPAN = 17'd20;
	localparam logic [OFF_W-1:0]  PTR_SKIP  = 17'd2;

	typedef struct packed {
		logic [BYTE_W-1:0] byte_value;
		logic              last_byte;
	} request_t;

	typedef struct packed {
		logic             is_match;
		logic [LEN_W-1:0] data_length;
	} result_t;

	typedef enum logic [2:0] {
		ASEL_MAGIC,
		ASEL_HDR,
		ASEL_ENTRY,
		ASEL_CNT,
		ASEL_PTR,
		ASEL_SEG
	} addr_sel_t;

	typedef enum logic [1:0] {
		RAISE_NONE,
		RAISE_PTR,
		RAISE_INST,
		RAISE_SEG
	} raise_sel_t;

	typedef enum logic [1:0] {
		PH_ORDER,
		PH_INST,
		PH_SEG
	} list_phase_t;

	// Controller to datapath
	typedef struct packed {
		logic        write;
		logic        walk_init;
		addr_sel_t   addr_sel;
		logic        hi;
		list_phase_t phase;
		logic        lo_ld;
		logic        base_ld;
		logic        ent_ld;
		logic        cnt_ld;
		logic        inner_clr;
		logic        inner_inc;
		logic        idx_clr;
		logic        idx_inc;
		raise_sel_t  raise;
		logic        report;
		logic        pass;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic addr_oob;
		logic magic_ok;
		logic magic_last;
		logic word_end;
		logic word_oob;
		logic byte_zero;
		logic byte_ff;
		logic ptr_last;
		logic scan_last;
		logic idx_last;
	} status_t;

endpackage

// ===== rtl/module_file_signature_validator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// module_file_signature_validator
// Stores a file byte by byte and checks its music module layout.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: a request (byte_value, last_byte) is taken at each rising
//   edge with start high and busy low. Bytes come in file order from offset
//   zero, one per cycle at most; bytes past MAX_LEN are dropped.
//   The request with last_byte set raises busy and starts the walk over the
//   stored file: magic, three header pointers, order lists, instrument list
//   and pattern segment scans.
//   Output channel: done is high for one cycle with result (is_match,
//   data_length); the receiver takes it at the end of that cycle and cannot
//   hold it off. busy drops after that cycle and the next byte starts a new
//   file at offset zero.
//   Walk steps: a single-byte read (magic, order count, segment byte) issues
//   the address, then uses the registered store read data; a 16-bit read
//   (header pointer, list entry, order pointer) reads the low byte, then the
//   high byte, then uses the word. The report state follows the last step.
//   A rejection ends the walk at the failing read.
//   Throughput: one byte per cycle while loading; the next file may start in
//   the cycle after the report.
//   Reset: asynchronous; clears the byte count and returns to loading.
// ----------------------------------------------------------------------------
module module_file_signature_validator #(
	parameter int MAX_LEN      = fsv_pkg::MAX_LEN_DEF,
	parameter int LIST_ENTRIES = fsv_pkg::LIST_ENTRIES_DEF,
	parameter int SCAN_LIMIT   = fsv_pkg::SCAN_LIMIT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  fsv_pkg::request_t request,
	output logic              busy,
	output logic              done,
	output fsv_pkg::result_t  result
);
	import fsv_pkg::*;

	cmd_t    cmd;
	status_t status;

	fsv_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.last_byte (request.last_byte),
		.status    (status),
		.cmd       (cmd),
		.busy      (busy),
		.done      (done)
	);

	fsv_datapath #(
		.MAX_LEN      (MAX_LEN),
		.LIST_ENTRIES (LIST_ENTRIES),
		.SCAN_LIMIT   (SCAN_LIMIT)
	) u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (request),
		.cmd     (cmd),
		.status  (status),
		.result  (result)
	);

	// Report returns the block to loading
	a_done_releases: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("busy still high after report");

	// A rejected file reports zero length
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.is_match) |-> (result.data_length == '0))
		else $error("nonzero length on reject");

	// Only the final byte starts a walk
	a_walk_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !request.last_byte) |=> !busy)
		else $error("walk started without last byte");

	// Walk starts only after a last-byte request
	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start && request.last_byte && cmd.write))
		else $error("busy raised without last-byte request");

endmodule

// ===== rtl/fsv_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsv_datapath
// File store, byte count, walk registers, address generation and flags.
// ----------------------------------------------------------------------------
module fsv_datapath #(
	parameter int MAX_LEN      = fsv_pkg::MAX_LEN_DEF,
	parameter int LIST_ENTRIES = fsv_pkg::LIST_ENTRIES_DEF,
	parameter int SCAN_LIMIT   = fsv_pkg::SCAN_LIMIT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  fsv_pkg::request_t  request,
	input  fsv_pkg::cmd_t      cmd,
	output fsv_pkg::status_t   status,
	output fsv_pkg::result_t   result
);
	import fsv_pkg::*;

	localparam int AW          = $clog2(MAX_LEN);
	localparam int CNT_W       = $clog2(MAX_LEN + 1);
	localparam int LI_W        = (LIST_ENTRIES > 1) ? $clog2(LIST_ENTRIES) : 1;
	localparam int INNER_SPAN  = (SCAN_LIMIT > 256) ? SCAN_LIMIT : 256;
	localparam int IN_W        = $clog2(INNER_SPAN);

	logic [BYTE_W-1:0] mem [MAX_LEN];
	logic [BYTE_W-1:0] rd_data_q;

	logic [CNT_W-1:0]  count_q;
	logic [BYTE_W-1:0] lo_q;
	logic [WORD_W-1:0] base_q;
	logic [WORD_W-1:0] ent_q;
	logic [BYTE_W-1:0] cnt_q;
	logic [IN_W-1:0]   inner_q;
	logic [LI_W-1:0]   idx_q;
	logic [LEN_W-1:0]  furthest_q;

	logic [OFF_W-1:0]  hdr_off;
	logic [OFF_W-1:0]  addr;
	logic [WORD_W-1:0] word_now;
	logic [LEN_W-1:0]  raise_val;
	logic              write_en;

	assign write_en = cmd.write && (count_q < CNT_W'(MAX_LEN));
	assign word_now = {rd_data_q, lo_q};

	always_comb begin
		case (cmd.phase)
			PH_ORDER: hdr_off = HDR_ORDER_OFF;
			PH_INST:  hdr_off = HDR_INST_OFF;
			PH_SEG:   hdr_off = HDR_SEG_OFF;
			default:  hdr_off = HDR_ORDER_OFF;
		endcase
	end

	always_comb begin
		unique case (cmd.addr_sel)
			ASEL_MAGIC: addr = OFF_W'(inner_q);
			ASEL_HDR:   addr = hdr_off + OFF_W'(cmd.hi);
			ASEL_ENTRY: addr = OFF_W'(base_q) + OFF_W'({idx_q, 1'b0}) + OFF_W'(cmd.hi);
			ASEL_CNT:   addr = OFF_W'(ent_q);
			ASEL_PTR:   addr = OFF_W'(ent_q) + PTR_SKIP + OFF_W'({inner_q, 1'b0})
				+ OFF_W'(cmd.hi);
			ASEL_SEG:   addr = OFF_W'(ent_q) + OFF_W'(inner_q);
			default:    addr = '0;
		endcase
	end

	always_comb begin
		case (cmd.raise)
			RAISE_PTR:  raise_val = LEN_W'(word_now);
			RAISE_INST: raise_val = LEN_W'(word_now) + LEN_W'(INST_SPAN);
			RAISE_SEG:  raise_val = LEN_W'(ent_q) + LEN_W'(inner_q) + LEN_W'(1);
			default:    raise_val = '0;
		endcase
	end

	// File store: one write port for loading, one registered read port for the walk
	always_ff @(posedge clk) begin
		if (write_en) begin
			mem[count_q[AW-1:0]] <= request.byte_value;
		end
		rd_data_q <= mem[AW'(addr)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			inner_q    <= '0;
			idx_q      <= '0;
			furthest_q <= '0;
		end else begin
			if (cmd.report) begin
				count_q <= '0;
			end else if (write_en) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (cmd.walk_init || cmd.inner_clr) begin
				inner_q <= '0;
			end else if (cmd.inner_inc) begin
				inner_q <= inner_q + IN_W'(1);
			end
			if (cmd.walk_init || cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + LI_W'(1);
			end
			if (cmd.walk_init) begin
				furthest_q <= '0;
			end else if (cmd.raise != RAISE_NONE && raise_val > furthest_q) begin
				furthest_q <= raise_val;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.lo_ld) begin
			lo_q <= rd_data_q;
		end
		if (cmd.base_ld) begin
			base_q <= word_now;
		end
		if (cmd.ent_ld) begin
			ent_q <= word_now;
		end
		if (cmd.cnt_ld) begin
			cnt_q <= rd_data_q;
		end
	end

	assign status.addr_oob   = CNT_W'(addr) >= count_q;
	assign status.magic_ok   = rd_data_q == MAGIC[inner_q[2:0]];
	assign status.magic_last = inner_q == IN_W'(MAGIC_LEN - 1);
	assign status.word_end   = word_now == END_MARK;
	assign status.word_oob   = CNT_W'(word_now) >= count_q;
	assign status.byte_zero  = rd_data_q == '0;
	assign status.byte_ff    = rd_data_q == SEG_END;
	assign status.ptr_last   = inner_q == IN_W'(cnt_q - 8'd1);
	assign status.scan_last  = inner_q == IN_W'(SCAN_LIMIT - 1);
	assign status.idx_last   = idx_q == LI_W'(LIST_ENTRIES - 1);

	assign result.is_match    = cmd.pass;
	assign result.data_length = cmd.pass ? furthest_q : '0;

endmodule

// ===== rtl/fsv_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsv_ctrl
// Sequencer for loading and for the header, list and segment walk.
// ----------------------------------------------------------------------------
module fsv_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               last_byte,
	input  fsv_pkg::status_t   status,
	output fsv_pkg::cmd_t      cmd,
	output logic               busy,
	output logic               done
);
	import fsv_pkg::*;

	typedef enum logic [16:0] {
		ST_LOAD      = 17'h00001,
		ST_MAGIC_RD  = 17'h00002,
		ST_MAGIC_USE = 17'h00004,
		ST_HDR_LO    = 17'h00008,
		ST_HDR_HI    = 17'h00010,
		ST_HDR_USE   = 17'h00020,
		ST_ENT_LO    = 17'h00040,
		ST_ENT_HI    = 17'h00080,
		ST_ENT_USE   = 17'h00100,
		ST_CNT_RD    = 17'h00200,
		ST_CNT_USE   = 17'h00400,
		ST_PTR_LO    = 17'h00800,
		ST_PTR_HI    = 17'h01000,
		ST_PTR_USE   = 17'h02000,
		ST_SEG_RD    = 17'h04000,
		ST_SEG_USE   = 17'h08000,
		ST_REPORT    = 17'h10000
	} ctrl_state_t;

	ctrl_state_t state_q, state_n;
	list_phase_t phase_q, phase_n;
	logic        pass_q, pass_n;
	logic        adv;
	logic        list_end;

	always_comb begin
		cmd           = '0;
		cmd.addr_sel  = ASEL_MAGIC;
		cmd.raise     = RAISE_NONE;
		cmd.phase     = phase_q;
		cmd.pass      = pass_q;
		state_n       = state_q;
		phase_n       = phase_q;
		pass_n        = pass_q;
		adv           = 1'b0;
		list_end      = 1'b0;

		unique case (state_q)
			ST_LOAD: begin
				cmd.write = start;
				if (start && last_byte) begin
					cmd.walk_init = 1'b1;
					phase_n       = PH_ORDER;
					state_n       = ST_MAGIC_RD;
				end
			end
			ST_MAGIC_RD: begin
				cmd.addr_sel = ASEL_MAGIC;
				state_n      = ST_MAGIC_USE;
			end
			ST_MAGIC_USE: begin
				if (!status.magic_ok) begin
					pass_n  = 1'b0;
					state_n = ST_REPORT;
				end else if (status.magic_last) begin
					state_n = ST_HDR_LO;
				end else begin
					cmd.inner_inc = 1'b1;
					state_n       = ST_MAGIC_RD;
				end
			end
			ST_HDR_LO: begin
				cmd.addr_sel = ASEL_HDR;
				state_n      = ST_HDR_HI;
			end
			ST_HDR_HI: begin
				cmd.addr_sel = ASEL_HDR;
				cmd.hi       = 1'b1;
				cmd.lo_ld    = 1'b1;
				state_n      = ST_HDR_USE;
			end
			ST_HDR_USE: begin
				cmd.base_ld = 1'b1;
				cmd.idx_clr = 1'b1;
				state_n     = ST_ENT_LO;
			end
			ST_ENT_LO: begin
				cmd.addr_sel = ASEL_ENTRY;
				state_n      = ST_ENT_HI;
			end
			ST_ENT_HI: begin
				cmd.addr_sel = ASEL_ENTRY;
				cmd.hi       = 1'b1;
				cmd.lo_ld    = 1'b1;
				state_n      = ST_ENT_USE;
			end
			ST_ENT_USE: begin
				cmd.ent_ld = 1'b1;
				if (status.word_end) begin
					list_end = 1'b1;
				end else if (phase_q == PH_ORDER) begin
					state_n = ST_CNT_RD;
				end else if (status.word_oob) begin
					pass_n  = 1'b0;
					state_n = ST_REPORT;
				end else if (phase_q == PH_INST) begin
					cmd.raise = RAISE_INST;
					adv       = 1'b1;
				end else begin
					cmd.inner_clr = 1'b1;
					state_n       = ST_SEG_RD;
				end
			end
			ST_CNT_RD: begin
				cmd.addr_sel = ASEL_CNT;
				state_n      = ST_CNT_USE;
			end
			ST_CNT_USE: begin
				cmd.cnt_ld    = 1'b1;
				cmd.inner_clr = 1'b1;
				if (status.byte_zero) begin
					adv = 1'b1;
				end else begin
					state_n = ST_PTR_LO;
				end
			end
			ST_PTR_LO: begin
				cmd.addr_sel = ASEL_PTR;
				state_n      = ST_PTR_HI;
			end
			ST_PTR_HI: begin
				cmd.addr_sel = ASEL_PTR;
				cmd.hi       = 1'b1;
				cmd.lo_ld    = 1'b1;
				state_n      = ST_PTR_USE;
			end
			ST_PTR_USE: begin
				cmd.raise = RAISE_PTR;
				if (status.ptr_last) begin
					adv = 1'b1;
				end else begin
					cmd.inner_inc = 1'b1;
					state_n       = ST_PTR_LO;
				end
			end
			ST_SEG_RD: begin
				cmd.addr_sel = ASEL_SEG;
				state_n      = ST_SEG_USE;
			end
			ST_SEG_USE: begin
				if (status.byte_ff) begin
					cmd.raise = RAISE_SEG;
					adv       = 1'b1;
				end else if (status.scan_last) begin
					pass_n  = 1'b0;
					state_n = ST_REPORT;
				end else begin
					cmd.inner_inc = 1'b1;
					state_n       = ST_SEG_RD;
				end
			end
			ST_REPORT: begin
				cmd.report = 1'b1;
				state_n    = ST_LOAD;
			end
			default: begin
				state_n = ST_LOAD;
			end
		endcase

		// Any byte read at or past the loaded length rejects the file
		if ((state_q == ST_MAGIC_RD || state_q == ST_HDR_LO || state_q == ST_HDR_HI ||
			state_q == ST_ENT_LO || state_q == ST_ENT_HI || state_q == ST_CNT_RD ||
			state_q == ST_PTR_LO || state_q == ST_PTR_HI || state_q == ST_SEG_RD) &&
			status.addr_oob) begin
			pass_n  = 1'b0;
			state_n = ST_REPORT;
		end

		// Advance to the next entry, or close this list and open the next one
		if (list_end || (adv && status.idx_last)) begin
			unique case (phase_q)
				PH_ORDER: begin
					phase_n = PH_INST;
					state_n = ST_HDR_LO;
				end
				PH_INST: begin
					phase_n = PH_SEG;
					state_n = ST_HDR_LO;
				end
				default: begin
					pass_n  = 1'b1;
					state_n = ST_REPORT;
				end
			endcase
		end else if (adv) begin
			cmd.idx_inc = 1'b1;
			state_n     = ST_ENT_LO;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			phase_q <= PH_ORDER;
			pass_q  <= 1'b0;
		end else begin
			state_q <= state_n;
			phase_q <= phase_n;
			pass_q  <= pass_n;
		end
	end

	assign busy = state_q != ST_LOAD;
	assign done = state_q == ST_REPORT;

endmodule
